// ----- src/bb3_pkg.sv -----
package bb3_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int DIM_W = 12;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = DIM_W + 1;
    localparam int POS_W = ROW_W + 2;
    localparam int CHAN_W = 8;
    localparam int SUM_W = 12;
    localparam int NUM_W = SUM_W + 1;
    localparam int CNT_W = 4;
    localparam int RECIP_W = 19;
    localparam int RECIP_SHIFT = 19;
    localparam int LINE_W = 6 * CHAN_W;

    localparam logic [DIM_W-1:0] WIDTH_RESET = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    // Which window rows and columns lie inside the frame, plus the end marker.
    typedef struct packed {
        logic [2:0] row_ok;
        logic [2:0] col_ok;
        logic       frame_end;
    } t_win_ctl;

    // Reciprocal of twice the neighbor count, scaled by 2**RECIP_SHIFT. The
    // constants are exact for every numerator the blur can produce.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = RECIP_W'(1 << (RECIP_SHIFT - 1));
            4'd2:    m = RECIP_W'(1 << (RECIP_SHIFT - 2));
            4'd3:    m = RECIP_W'(87382);
            4'd4:    m = RECIP_W'(1 << (RECIP_SHIFT - 3));
            4'd6:    m = RECIP_W'(43691);
            4'd9:    m = RECIP_W'(29128);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- src/bb3_ram.sv -----
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- src/bb3_norm.sv -----
module bb3_norm (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  bb3_pkg::t_pixel [8:0]    i_win,
    input  bb3_pkg::t_win_ctl        i_ctl,
    output logic                     o_ready,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    output logic                     o_frame_end
);
    import bb3_pkg::*;

    logic                          adv_out;
    logic                          s2_ready;
    logic [1:0]                    n_rows;
    logic [1:0]                    n_cols;
    logic [CNT_W-1:0]              cnt;
    logic [SUM_W-1:0]              sum [3];
    logic [NUM_W-1:0]              num [3];
    logic [NUM_W+RECIP_W-1:0]      prod [3];

    logic                          r_s2_v;
    logic [NUM_W-1:0]              r_num [3];
    logic [RECIP_W-1:0]            r_recip;
    logic                          r_s2_end;
    logic                          r_out_v;
    logic [CHAN_W-1:0]             r_out [3];
    logic                          r_out_end;

    assign adv_out  = !r_out_v || !i_stall;
    assign s2_ready = !r_s2_v || adv_out;
    assign o_ready  = s2_ready;

    // Masked window sums and the round-half-up numerator 2*S + n.
    always_comb begin
        n_rows = 2'($countones(i_ctl.row_ok));
        n_cols = 2'($countones(i_ctl.col_ok));
        cnt = CNT_W'(n_rows) * CNT_W'(n_cols);
        for (int k = 0; k < 3; k++) begin
            sum[k] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i_ctl.row_ok[i] && i_ctl.col_ok[j]) begin
                    sum[0] = sum[0] + SUM_W'(i_win[i*3+j].red);
                    sum[1] = sum[1] + SUM_W'(i_win[i*3+j].green);
                    sum[2] = sum[2] + SUM_W'(i_win[i*3+j].blue);
                end
            end
        end
        for (int k = 0; k < 3; k++) begin
            num[k] = {sum[k], 1'b0} + NUM_W'(cnt);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k] = (NUM_W+RECIP_W)'(r_num[k]) * (NUM_W+RECIP_W)'(r_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_v <= i_valid;
            end
            if (adv_out) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= num[k];
            end
            r_recip  <= recip(cnt);
            r_s2_end <= i_ctl.frame_end;
        end
        if (adv_out && r_s2_v) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= prod[k][RECIP_SHIFT +: CHAN_W];
            end
            r_out_end <= r_s2_end;
        end
    end

    assign o_valid     = r_out_v;
    assign o_red       = r_out[0];
    assign o_green     = r_out[1];
    assign o_blue      = r_out[2];
    assign o_frame_end = r_out_end;

endmodule

// ----- src/box_blur_3x3_edge_aware.sv -----
// Channel  Handshake            Payload
// in       i_valid / o_stall    i_command, i_in_red, i_in_green, i_in_blue
// out      o_valid / i_stall    o_out_red, o_out_green, o_out_blue, o_frame_end
// cfg      i_cfg_we             i_cfg_index, i_cfg_data
//
// One item is accepted per clock while o_stall is low; a result passes the
// window register, sum stage and divide stage after its window completes.
// The line stores sit in one block RAM whose registered read is prefetched
// for the next column, so each column is read and rewritten once per item.
// Reset is synchronous and needs no clearing pass; o_stall is high during it.
// A stalled output holds its item while the two stages behind it keep filling.
module box_blur_3x3_edge_aware (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic [7:0]                i_in_red,
    input  logic [7:0]                i_in_green,
    input  logic [7:0]                i_in_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [7:0]                o_out_red,
    output logic [7:0]                o_out_green,
    output logic [7:0]                o_out_blue,
    output logic                      o_frame_end,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [bb3_pkg::DIM_W-1:0] i_cfg_data
);
    import bb3_pkg::*;

    logic [DIM_W-1:0]        r_width;
    logic [DIM_W-1:0]        r_height;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        n_col;
    logic [ROW_W-1:0]        n_row;
    logic                    r_s1_v;
    t_win_ctl                r_ctl;
    t_pixel [8:0]            r_win;
    logic                    r_byp;
    logic [LINE_W-1:0]       r_byp_data;

    logic [WID_W-1:0]        w_eff;
    logic [DIM_W-1:0]        h_eff;
    logic signed [POS_W-1:0] pos_r;
    logic signed [POS_W-1:0] pos_c;
    logic signed [POS_W-1:0] pw;
    logic signed [POS_W-1:0] ph;
    logic signed [POS_W-1:0] pr;
    logic signed [POS_W-1:0] pc;
    logic                    has_res;
    t_win_ctl                ctl;
    t_pixel                  cur;
    logic                    norm_ready;
    logic                    in_ready;
    logic                    accept;
    logic [COL_W-1:0]        rd_addr;
    logic [LINE_W-1:0]       ram_q;
    logic [LINE_W-1:0]       line_pair;
    logic [LINE_W-1:0]       wr_data;

    assign in_ready = !r_s1_v || norm_ready;
    assign o_stall  = !in_ready || !i_rst_n;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        if (r_width == '0) begin
            w_eff = WID_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_width);
        end
        h_eff = (r_height == '0) ? DIM_W'(1) : r_height;
    end

    // Slot position, window center and the in-frame masks for this item.
    always_comb begin
        pos_r = signed'(POS_W'(r_row));
        pos_c = signed'(POS_W'(r_col));
        pw    = signed'(POS_W'(w_eff));
        ph    = signed'(POS_W'(h_eff));
        if (r_col != '0) begin
            pr = pos_r - POS_W'(1);
            pc = pos_c - POS_W'(1);
        end else begin
            pr = pos_r - POS_W'(2);
            pc = pw - POS_W'(1);
        end
        has_res = (pr >= 0) && (pr < ph) && (pc < pw);
        ctl.row_ok = {(pr + POS_W'(1)) < ph, 1'b1, pr >= POS_W'(1)};
        ctl.col_ok = {(pc + POS_W'(1)) < pw, 1'b1, pc >= POS_W'(1)};
        ctl.frame_end = (pr == ph - POS_W'(1)) && (pc == pw - POS_W'(1));

        if (pos_r >= ph + POS_W'(1)) begin
            n_col = '0;
            n_row = '0;
        end else if (pos_c + POS_W'(1) >= pw) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end

        if (!i_command && (pos_r < ph)) begin
            cur = '{red: i_in_red, green: i_in_green, blue: i_in_blue};
        end else begin
            cur = '0;
        end
    end

    // The RAM output always belongs to the current column; when the column
    // just written is read again at once, the written value is forwarded.
    assign rd_addr   = accept ? n_col : r_col;
    assign line_pair = r_byp ? r_byp_data : ram_q;
    assign wr_data   = {line_pair[LINE_W/2-1:0], cur};

    bb3_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_col),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_byp  <= 1'b0;
        end else begin
            r_byp <= accept && (n_col == r_col);
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_s1_v <= has_res;
            end else if (norm_ready) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2]   <= t_pixel'(line_pair[LINE_W-1:LINE_W/2]);
            r_win[5]   <= t_pixel'(line_pair[LINE_W/2-1:0]);
            r_win[8]   <= cur;
            r_ctl      <= ctl;
            r_byp_data <= wr_data;
        end
    end

    bb3_norm u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s1_v),
        .i_win      (r_win),
        .i_ctl      (r_ctl),
        .o_ready    (norm_ready),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_red      (o_out_red),
        .o_green    (o_out_green),
        .o_blue     (o_out_blue),
        .o_frame_end(o_frame_end)
    );

`ifndef NO_ASSERTIONS
    a_bypass_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp |-> (r_col == '0))
        else $error("forwarded line data outside column zero");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && has_res) |=> r_s1_v)
        else $error("item with a result left no window entry");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_v |-> !o_stall)
        else $error("input stalled with an empty window stage");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(2 ** DIM_W))
        else $error("row counter past the drain rows");
`endif

endmodule
